// ===== hdl/mof_scalar_point_op_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the point op scheduler
// concurrent checks, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef MOF_SCALAR_POINT_OP_SCHEDULER_ASSERT_SVH
`define MOF_SCALAR_POINT_OP_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
`define MSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("msp assertion failed");
`define MSP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("msp assertion failed");
`else
`define MSP_ASSERT_IMP(lbl, ante, cons)
`define MSP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// shared types and codes of the point op scheduler
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam logic [2:0] KIND_LOAD = 3'd0;
    localparam logic [2:0] KIND_ADD  = 3'd1;
    localparam logic [2:0] KIND_XADD = 3'd2;
    localparam logic [2:0] KIND_DBLX = 3'd3;
    localparam logic [2:0] KIND_DBL  = 3'd4;

    localparam logic [1:0] CFG_DUAL  = 2'd0;
    localparam logic [1:0] CFG_WIDTH = 2'd1;
    localparam logic [1:0] CFG_WORDS = 2'd2;

    localparam int MAX_RESULTS = 64;
    localparam int WIN_MIN     = 3;
    localparam int WORDS_MAX   = 16;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD_K,
        OP_LOAD_L,
        OP_DBL,
        OP_ADD1,
        OP_DBL2,
        OP_ADD2,
        OP_FINAL
    } t_op;

    typedef struct packed {
        logic       accept;
        logic       first;
        logic       dual;
        logic [3:0] w;
        logic       last_word;
        t_op        op;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic differ;
        logic more;
        logic final_need;
    } t_stat;

endpackage

// ===== hdl/msp_datapath.sv =====
// ----------------------------------------------------------------------------
// msp_datapath
// word buffers, window extraction and decode, doubling counts, output word
// ----------------------------------------------------------------------------
module msp_datapath #(
    parameter int WORD_BITS  = 32,
    parameter int MAX_WINDOW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msp_pkg::t_cmd        i_cmd,
    output msp_pkg::t_stat       o_stat,
    input  logic [WORD_BITS-1:0] i_k_word,
    input  logic [WORD_BITS-1:0] i_l_word,
    input  logic                 i_k_top_bit,
    input  logic                 i_l_top_bit,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_op_kind,
    output logic [4:0]           o_repeat_count,
    output logic                 o_table_select,
    output logic [7:0]           o_table_entry,
    output logic                 o_last_command
);
    import msp_pkg::*;

    localparam int SHW  = $clog2(WORD_BITS) + 2;
    localparam int EXTW = 2 * WORD_BITS + MAX_WINDOW;
    localparam int AMTW = $clog2(EXTW);

    function automatic logic [11:0] f_decode(input logic [8:0] bits, input logic [3:0] w);
        logic [7:0] mask;
        logic       neg;
        logic [7:0] x;
        logic [8:0] zs;
        logic [7:0] z;
        logic [3:0] d;
        logic [7:0] odd;
        logic [8:0] ow;
        logic [7:0] ent;
        begin
            mask = 8'((9'd1 << w) - 9'd1);
            neg  = bits[w];
            x    = (bits[7:0] & mask) ^ (neg ? mask : 8'd0);
            zs   = ({1'b0, x} + 9'd1) >> 1;
            z    = zs[7:0];
            d    = 4'd0;
            for (int i = 7; i >= 0; i--) begin
                if (z[i]) begin
                    d = 4'(i);
                end
            end
            odd = z >> d;
            ow  = ({1'b0, odd} + 9'd1) >> 1;
            ent = ow[7:0] + (neg ? 8'(9'd1 << (w - 4'd2)) : 8'd0);
            if (z == 8'd0) begin
                d   = w - 4'd1;
                ent = 8'd0;
            end
            return {d, ent};
        end
    endfunction

    logic [WORD_BITS-1:0]   r_khi, r_klo, r_lhi, r_llo;
    logic signed [SHW-1:0]  r_sh;
    logic [4:0]             r_pend;
    logic [3:0]             r_skip;
    logic [6:0]             r_cnt;
    logic                   r_ovalid;
    logic [2:0]             r_kind;
    logic [4:0]             r_rep;
    logic                   r_sel;
    logic [7:0]             r_ent;
    logic                   r_last;

    logic signed [SHW-1:0]  w_s, sh_new;
    logic signed [SHW:0]    amt_s;
    logic [AMTW-1:0]        amt;
    logic [EXTW-1:0]        ext_k, ext_l;
    logic [MAX_WINDOW:0]    win_k, win_l;
    logic [11:0]            dec_k, dec_l;
    logic [3:0]             dk, dl, a1, a2, a_low, skip_new;
    logic [7:0]             ek, el, e1, e2;
    logic                   k_first, s1, s2, differ, more, final_need, win_end;
    logic                   write, keep, nat_last;
    logic [2:0]             n_kind;
    logic [4:0]             n_rep;
    logic                   n_sel;
    logic [7:0]             n_ent;

    assign w_s    = signed'(SHW'(i_cmd.w));
    assign sh_new = r_sh - w_s;
    assign amt_s  = (SHW+1)'(r_sh) + (SHW+1)'(MAX_WINDOW);
    assign amt    = AMTW'(unsigned'(amt_s));
    assign ext_k  = {r_khi, r_klo, MAX_WINDOW'(0)};
    assign ext_l  = {r_lhi, r_llo, MAX_WINDOW'(0)};
    assign win_k  = (MAX_WINDOW+1)'(ext_k >> amt);
    assign win_l  = (MAX_WINDOW+1)'(ext_l >> amt);
    assign dec_k  = f_decode(9'(win_k), i_cmd.w);
    assign dec_l  = f_decode(9'(win_l), i_cmd.w);
    assign dk     = dec_k[11:8];
    assign ek     = dec_k[7:0];
    assign dl     = dec_l[11:8];
    assign el     = dec_l[7:0];

    assign k_first = !i_cmd.dual || (dk >= dl);
    assign a1      = k_first ? dk : dl;
    assign a2      = k_first ? dl : dk;
    assign e1      = k_first ? ek : el;
    assign e2      = k_first ? el : ek;
    assign s1      = !k_first;
    assign s2      = k_first;
    assign a_low   = i_cmd.dual ? a2 : dk;
    assign differ  = a1 != a2;

    assign more       = !sh_new[SHW-1] || (i_cmd.last_word && !r_sh[SHW-1]);
    assign skip_new   = r_sh[SHW-1] ? 4'(~r_sh) : r_skip;
    assign final_need = a_low > skip_new;
    assign win_end    = (i_cmd.op == OP_ADD2) || (i_cmd.op == OP_ADD1 && !i_cmd.dual);

    assign write = i_cmd.op != OP_NONE;
    assign keep  = r_cnt < 7'(MAX_RESULTS);

    always_comb begin
        n_kind   = KIND_ADD;
        n_rep    = 5'd0;
        n_sel    = 1'b0;
        n_ent    = 8'd0;
        nat_last = 1'b0;
        case (i_cmd.op)
            OP_LOAD_K: begin
                n_kind = KIND_LOAD;
                n_ent  = {7'd0, r_khi[0]};
            end
            OP_LOAD_L: begin
                n_sel = 1'b1;
                n_ent = {7'd0, r_lhi[0]};
            end
            OP_DBL: begin
                n_kind = KIND_DBLX;
                n_rep  = r_pend + {1'b0, i_cmd.w} - {1'b0, a1};
            end
            OP_ADD1: begin
                n_kind   = (i_cmd.dual && !differ) ? KIND_XADD : KIND_ADD;
                n_sel    = s1 & i_cmd.dual;
                n_ent    = e1;
                nat_last = win_end && i_cmd.last_word && !more && !final_need;
            end
            OP_DBL2: begin
                n_kind = KIND_DBLX;
                n_rep  = {1'b0, a1 - a2};
            end
            OP_ADD2: begin
                n_sel    = s2;
                n_ent    = e2;
                nat_last = i_cmd.last_word && !more && !final_need;
            end
            OP_FINAL: begin
                n_kind   = KIND_DBL;
                n_rep    = r_pend - {1'b0, r_skip};
                nat_last = i_cmd.last_word;
            end
            default: begin
                n_kind = KIND_ADD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_khi <= i_cmd.first ? {{(WORD_BITS-1){1'b0}}, i_k_top_bit} : r_klo;
            r_klo <= i_k_word;
            r_lhi <= i_cmd.first ? {{(WORD_BITS-1){1'b0}}, i_l_top_bit & i_cmd.dual} : r_llo;
            r_llo <= i_cmd.dual ? i_l_word : {WORD_BITS{1'b0}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh   <= SHW'(WORD_BITS + 5);
            r_pend <= 5'd0;
            r_skip <= 4'd0;
            r_cnt  <= 7'd0;
        end else if (i_cmd.accept) begin
            r_sh  <= i_cmd.first ? SHW'(WORD_BITS) - w_s : SHW'(WORD_BITS) + r_sh;
            r_cnt <= 7'd0;
            if (i_cmd.first) begin
                r_pend <= 5'd0;
                r_skip <= 4'd0;
            end
        end else begin
            if (write && keep) begin
                r_cnt <= r_cnt + 7'd1;
            end
            if (win_end) begin
                r_pend <= {1'b0, a_low};
                r_sh   <= sh_new;
                r_skip <= skip_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (write && keep) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (write && keep) begin
            r_kind <= n_kind;
            r_rep  <= n_rep;
            r_sel  <= n_sel;
            r_ent  <= n_ent;
            r_last <= nat_last || (i_cmd.last_word && r_cnt == 7'(MAX_RESULTS - 1));
        end
    end

    assign o_stat.out_free   = !r_ovalid || i_out_ready;
    assign o_stat.differ     = differ;
    assign o_stat.more       = more;
    assign o_stat.final_need = final_need;

    assign o_out_valid    = r_ovalid;
    assign o_op_kind      = r_kind;
    assign o_repeat_count = r_rep;
    assign o_table_select = r_sel;
    assign o_table_entry  = r_ent;
    assign o_last_command = r_last;

endmodule

// ===== hdl/msp_ctrl.sv =====
// ----------------------------------------------------------------------------
// msp_ctrl
// configuration registers, word counter and command sequencer
// ----------------------------------------------------------------------------
`include "mof_scalar_point_op_scheduler_assert.svh"

module msp_ctrl #(
    parameter int MAX_WINDOW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [4:0]     i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  msp_pkg::t_stat i_stat,
    output msp_pkg::t_cmd  o_cmd
);
    import msp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOAD_K = 8'b0000_0010,
        S_LOAD_L = 8'b0000_0100,
        S_DBL    = 8'b0000_1000,
        S_ADD1   = 8'b0001_0000,
        S_DBL2   = 8'b0010_0000,
        S_ADD2   = 8'b0100_0000,
        S_FINAL  = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state, win_next;
    logic       r_cfg_dual, r_dual, r_last;
    logic [3:0] r_cfg_w, r_w, w_cl;
    logic [4:0] r_cfg_words, r_words, words_cl, cur_words, r_taken, n_taken;
    logic       accept, first, fire, cur_dual;
    logic [3:0] cur_w;
    t_op        op;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = r_state == S_IDLE;
    assign accept      = i_in_valid && o_in_ready;
    assign first       = r_taken == 5'd0;
    assign fire        = (r_state != S_IDLE) && i_stat.out_free;

    assign w_cl = (r_cfg_w < 4'(WIN_MIN)) ? 4'(WIN_MIN) :
                  (r_cfg_w > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : r_cfg_w;
    assign words_cl = (r_cfg_words == 5'd0) ? 5'd1 :
                      (r_cfg_words > 5'(WORDS_MAX)) ? 5'(WORDS_MAX) : r_cfg_words;

    assign cur_w     = (accept && first) ? w_cl : r_w;
    assign cur_dual  = (accept && first) ? r_cfg_dual : r_dual;
    assign cur_words = first ? words_cl : r_words;
    assign n_taken   = r_taken + 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dual  <= 1'b0;
            r_cfg_w     <= 4'd5;
            r_cfg_words <= 5'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DUAL:  r_cfg_dual  <= i_cfg_data[0];
                CFG_WIDTH: r_cfg_w     <= i_cfg_data[3:0];
                CFG_WORDS: r_cfg_words <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dual  <= 1'b0;
            r_w     <= 4'd5;
            r_words <= 5'd8;
            r_taken <= 5'd0;
            r_last  <= 1'b0;
        end else if (accept) begin
            r_dual  <= cur_dual;
            r_w     <= cur_w;
            r_words <= cur_words;
            r_last  <= n_taken >= cur_words;
            r_taken <= (n_taken >= cur_words) ? 5'd0 : n_taken;
        end
    end

    always_comb begin
        if (i_stat.more) begin
            win_next = S_DBL;
        end else if (r_last && i_stat.final_need) begin
            win_next = S_FINAL;
        end else begin
            win_next = S_IDLE;
        end
    end

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = first ? S_LOAD_K : S_DBL;
                end
            end
            S_LOAD_K: begin
                op = OP_LOAD_K;
                if (fire) n_state = r_dual ? S_LOAD_L : S_DBL;
            end
            S_LOAD_L: begin
                op = OP_LOAD_L;
                if (fire) n_state = S_DBL;
            end
            S_DBL: begin
                op = OP_DBL;
                if (fire) n_state = S_ADD1;
            end
            S_ADD1: begin
                op = OP_ADD1;
                if (fire) begin
                    if (!r_dual) n_state = win_next;
                    else n_state = i_stat.differ ? S_DBL2 : S_ADD2;
                end
            end
            S_DBL2: begin
                op = OP_DBL2;
                if (fire) n_state = S_ADD2;
            end
            S_ADD2: begin
                op = OP_ADD2;
                if (fire) n_state = win_next;
            end
            S_FINAL: begin
                op = OP_FINAL;
                if (fire) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept    = accept;
    assign o_cmd.first     = first;
    assign o_cmd.dual      = cur_dual;
    assign o_cmd.w         = cur_w;
    assign o_cmd.last_word = r_last;
    assign o_cmd.op        = fire ? op : OP_NONE;

    `MSP_ASSERT_NXT(a_accept_start, accept, (r_state == S_LOAD_K || r_state == S_DBL))
    `MSP_ASSERT_IMP(a_final_last, (r_state == S_FINAL), r_last)
    `MSP_ASSERT_IMP(a_single_path, !r_dual,
        !(r_state == S_LOAD_L || r_state == S_DBL2 || r_state == S_ADD2))
    `MSP_ASSERT_NXT(a_width_held, (r_state != S_IDLE), $stable(r_w))

endmodule

// ===== hdl/mof_scalar_point_op_scheduler.sv =====
// the first command of a word is issued from the state entered on accept and then held in the output register
// a new word is accepted only once the sequencer is idle again, after all commands of the last word are issued
// a word makes about WORD_BITS / window_width windows of two to four commands each
// the command sequencer issues one command per cycle; output stalls hold it
// reset: synchronous active low; restores register defaults and starts a new scalar
// ----------------------------------------------------------------------------
// mof_scalar_point_op_scheduler
// windowed mutual opposite form recoding into a point operation command stream
// ----------------------------------------------------------------------------
module mof_scalar_point_op_scheduler #(
    parameter int WORD_BITS  = 32,
    parameter int MAX_WINDOW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [4:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [WORD_BITS-1:0] i_k_word,
    input  logic [WORD_BITS-1:0] i_l_word,
    input  logic                 i_k_top_bit,
    input  logic                 i_l_top_bit,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_op_kind,
    output logic [4:0]           o_repeat_count,
    output logic                 o_table_select,
    output logic [7:0]           o_table_entry,
    output logic                 o_last_command
);
    import msp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    msp_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    msp_datapath #(
        .WORD_BITS  (WORD_BITS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_k_word       (i_k_word),
        .i_l_word       (i_l_word),
        .i_k_top_bit    (i_k_top_bit),
        .i_l_top_bit    (i_l_top_bit),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_op_kind      (o_op_kind),
        .o_repeat_count (o_repeat_count),
        .o_table_select (o_table_select),
        .o_table_entry  (o_table_entry),
        .o_last_command (o_last_command)
    );

endmodule

// ===== tb/tb_mof_scalar_point_op_scheduler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mof_scalar_point_op_scheduler
// self-checking bench for the w-mof point op scheduler: scalar words go in
// with random gaps, a local recoder predicts the command stream and every
// command leaving the block is compared with the oldest prediction
// ----------------------------------------------------------------------------
module tb_mof_scalar_point_op_scheduler;
    import msp_pkg::*;

    localparam int WB = 32;

    typedef struct {
        logic [2:0] kind;
        logic [4:0] rep;
        logic       sel;
        logic [7:0] entry;
        logic       last;
    } t_exp_cmd;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index = '0;
    logic [4:0]    i_cfg_data = '0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    logic [WB-1:0] i_k_word = '0;
    logic [WB-1:0] i_l_word = '0;
    logic          i_k_top_bit = 1'b0;
    logic          i_l_top_bit = 1'b0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    logic [2:0]    o_op_kind;
    logic [4:0]    o_repeat_count;
    logic          o_table_select;
    logic [7:0]    o_table_entry;
    logic          o_last_command;

    mof_scalar_point_op_scheduler dut (.*);

    t_exp_cmd    cmd_q[$];
    t_exp_cmd    step_cmds[$];
    int          errors = 0;
    bit          no_gaps = 0;
    int          rx_hold = 0;

    // predictor copies of registers and recoding state
    int unsigned cfg_dual = 0, cfg_width = 5, cfg_words = 8;
    int unsigned run_dual = 0, run_w = 5, run_words = 8;
    logic [63:0] k_prev = 0, l_prev = 0;
    int unsigned bit_pos = WB + 5, dbl_pend = 0, dbl_skip = 0, words_in = 0;

    initial forever #4 i_clk = ~i_clk;

    function automatic int unsigned draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void add_cmd(int unsigned kind, int unsigned rep,
                                    int unsigned sel, int unsigned entry);
        t_exp_cmd c;
        if (step_cmds.size() >= MAX_RESULTS) return;
        c.kind = kind[2:0];
        c.rep = rep[4:0];
        c.sel = sel[0];
        c.entry = entry[7:0];
        c.last = 1'b0;
        step_cmds.push_back(c);
    endfunction

    function automatic int unsigned win_decode(logic [63:0] bits, int unsigned w,
                                               output int unsigned entry);
        int unsigned low, neg, z, d;
        low = (1 << w) - 1;
        neg = bits[w];
        z = (((bits[31:0] & low) ^ (neg ? low : 0)) + 1) >> 1;
        d = 0;
        if (z == 0) begin
            entry = 0;
            return w - 1;
        end
        while ((z & 1) == 0) begin
            z = z >> 1;
            d++;
        end
        entry = ((z + 1) >> 1) + (neg ? (1 << (w - 2)) : 0);
        return d;
    endfunction

    function automatic void window_cmds(logic [63:0] bk, logic [63:0] bl);
        int unsigned ek, el, dk, dl, a1, a2, e1, e2, s1, s2;
        dk = win_decode(bk, run_w, ek);
        if (run_dual == 0) begin
            dbl_pend += run_w - dk;
            add_cmd(KIND_DBLX, dbl_pend, 0, 0);
            add_cmd(KIND_ADD, 0, 0, ek);
            dbl_pend = dk;
            return;
        end
        dl = win_decode(bl, run_w, el);
        if (dk >= dl) begin
            a1 = dk; a2 = dl; e1 = ek; e2 = el; s1 = 0; s2 = 1;
        end else begin
            a1 = dl; a2 = dk; e1 = el; e2 = ek; s1 = 1; s2 = 0;
        end
        dbl_pend += run_w - a1;
        add_cmd(KIND_DBLX, dbl_pend, 0, 0);
        if (a1 != a2) begin
            add_cmd(KIND_ADD, 0, s1, e1);
            add_cmd(KIND_DBLX, a1 - a2, 0, 0);
        end else begin
            add_cmd(KIND_XADD, 0, s1, e1);
        end
        add_cmd(KIND_ADD, 0, s2, e2);
        dbl_pend = a2;
    endfunction

    function automatic void predict_word(logic [WB-1:0] kw_in, logic [WB-1:0] lw_in,
                                         logic kt, logic lt);
        logic [63:0] kw, lw;
        int unsigned off, sh, s;
        step_cmds.delete();
        if (words_in == 0) begin
            run_dual = cfg_dual;
            run_w = cfg_width < 3 ? 3 : (cfg_width > 8 ? 8 : cfg_width);
            run_words = cfg_words == 0 ? 1 : (cfg_words > 16 ? 16 : cfg_words);
            bit_pos = WB + run_w;
            dbl_pend = 0;
            dbl_skip = 0;
            k_prev = kt;
            l_prev = run_dual ? lt : 0;
            add_cmd(KIND_LOAD, 0, 0, k_prev[0]);
            if (run_dual) add_cmd(KIND_ADD, 0, 1, l_prev[0]);
        end
        kw = kw_in;
        lw = run_dual ? lw_in : 0;
        off = bit_pos - WB;
        window_cmds((k_prev << off) | (kw >> (WB - off)), (l_prev << off) | (lw >> (WB - off)));
        k_prev = kw;
        l_prev = lw;
        bit_pos = off + run_w;
        while (bit_pos <= WB) begin
            sh = WB - bit_pos;
            window_cmds(k_prev >> sh, l_prev >> sh);
            bit_pos += run_w;
        end
        words_in++;
        if (words_in >= run_words) begin
            while (bit_pos <= WB + run_w) begin
                s = bit_pos - WB;
                dbl_skip = s - 1;
                window_cmds(k_prev << s, l_prev << s);
                bit_pos += run_w;
            end
            if (dbl_pend > dbl_skip) add_cmd(KIND_DBL, dbl_pend - dbl_skip, 0, 0);
            if (step_cmds.size() > 0) step_cmds[step_cmds.size() - 1].last = 1'b1;
            words_in = 0;
        end
        foreach (step_cmds[i]) cmd_q.push_back(step_cmds[i]);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic send_word(logic [WB-1:0] kw, logic [WB-1:0] lw, logic kt, logic lt);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_k_word <= kw;
        i_l_word <= lw;
        i_k_top_bit <= kt;
        i_l_top_bit <= lt;
        do @(posedge i_clk); while (!o_in_ready);
        predict_word(kw, lw, kt, lt);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DUAL:  cfg_dual = val & 1;
            CFG_WIDTH: cfg_width = val & 15;
            CFG_WORDS: cfg_words = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(int unsigned dual, int unsigned w, int unsigned nw);
        write_reg(CFG_DUAL, 2'(dual));
        write_reg(CFG_WIDTH, 5'(w));
        write_reg(CFG_WORDS, 5'(nw));
    endtask

    function automatic logic [WB-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int n);
        repeat (n) send_word(rand_word(), rand_word(), $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    // reset defaults, extreme words, negative zero and all-zero windows
    task automatic test_defaults();
        send_word('0, '0, 1'b0, 1'b0);
        send_word('1, '1, 1'b1, 1'b1);
        send_word(32'haaaa_aaaa, 32'h5555_5555, 1'b0, 1'b0);
        send_word(32'h8000_0001, 32'h0, 1'b0, 1'b0);
        send_word('1, '0, 1'b0, 1'b0);
        send_word('0, '1, 1'b0, 1'b0);
        send_word(32'h7fff_ffff, 32'h1, 1'b0, 1'b0);
        send_word(32'hdead_beef, 32'h1234_5678, 1'b0, 1'b0);
    endtask

    task automatic test_dual_directed();
        set_mode(1, 3, 2);
        send_word('1, '0, 1'b1, 1'b0);
        send_word('0, '1, 1'b0, 1'b1);
        set_mode(1, 8, 1);
        send_word('1, '1, 1'b1, 1'b1);
        send_word(32'hf0f0_0f0f, 32'h0f0f_f0f0, 1'b0, 1'b1);
    endtask

    task automatic test_odd_settings();
        set_mode(0, 2, 0);
        send_word(32'h1357_9bdf, 32'h0, 1'b1, 1'b0);
        send_word('0, '0, 1'b0, 1'b0);
        set_mode(1, 15, 31);
        repeat (3) send_word($urandom, $urandom, 1'b1, 1'b1);
        set_mode(0, 7, 16);
        repeat (5) send_word('1, $urandom, 1'b0, 1'b1);
    endtask

    task automatic test_random_sweep();
        int unsigned nw;
        repeat (60) begin
            nw = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 4);
            set_mode($urandom_range(0, 1), $urandom_range(3, 8), nw);
            no_gaps = ($urandom_range(0, 3) == 0);
            send_random(nw * $urandom_range(1, 2));
        end
        no_gaps = 0;
        set_mode($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 31));
        send_random(20);
    endtask

    task automatic test_backpressure();
        set_mode(1, 3, 4);
        rx_hold = 3000;
        no_gaps = 1;
        send_random(16);
        wait_idle();
        no_gaps = 0;
        send_random(12);
    endtask

    // command receiver
    initial begin
        int unsigned gap;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            gap = draw_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // command checker
    always @(posedge i_clk) begin
        t_exp_cmd want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cmd_q.size() == 0) begin
                report_mismatch("unexpected word, kind", o_op_kind, -1);
            end else begin
                want = cmd_q.pop_front();
                if (o_op_kind !== want.kind) report_mismatch("op_kind", o_op_kind, want.kind);
                if (o_repeat_count !== want.rep)
                    report_mismatch("repeat_count", o_repeat_count, want.rep);
                if (o_table_select !== want.sel)
                    report_mismatch("table_select", o_table_select, want.sel);
                if (o_table_entry !== want.entry)
                    report_mismatch("table_entry", o_table_entry, want.entry);
                if (o_last_command !== want.last)
                    report_mismatch("last_command", o_last_command, want.last);
            end
        end
    end

    initial begin
        #(20_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_dual_directed();
        test_odd_settings();
        test_random_sweep();
        test_backpressure();
        wait_idle();
        repeat (50) @(posedge i_clk);
        if (cmd_q.size() != 0) begin
            $display("leftover commands: %0d", cmd_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
